@@ rtl/dhpq_pkg.sv @@
// shared types, codes and default sizes for the d-ary heap priority queue
// no dependencies
package dhpq_pkg;

  localparam int unsigned DefCapacity    = 1024;
  localparam int unsigned DefKeyBits     = 32;
  localparam int unsigned DefPayloadBits = 32;
  localparam int unsigned DefMaxArity    = 8;

  typedef enum logic [1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } qstat_e;

  typedef enum logic [0:0] {
    REG_ARITY = 1'b0,
    REG_ORDER = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_FULL,
    OP_EMPTY,
    OP_CLEAR,
    OP_PUSH,
    OP_DIV_START,
    OP_UP_READ,
    OP_UP_STEP,
    OP_PLACE,
    OP_RD_ROOT,
    OP_TAKE,
    OP_POP_TAKE,
    OP_LAST_LOAD,
    OP_DN_INIT,
    OP_DN_ACC
  } dp_op_e;

  // two more ops than fit in the enum above are kept separate
  typedef enum logic [1:0] {
    OP2_NONE,
    OP2_DN_STEP,
    OP2_OUT
  } dp_op2_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] payload;
  } in_item_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] top_key;
    logic [31:0] top_payload;
    logic [10:0] count;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    dp_op_e  op;
    dp_op2_e op2;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  full;
    logic  empty;
    logic  pos_zero;
    logic  div_done;
    logic  up_move;
    logic  dn_leaf;
    logic  dn_more;
    logic  dn_move;
    logic  out_busy;
  } dp_status_t;

endpackage

@@ rtl/dary_heap_priority_queue_top.sv @@
// pop: one read per child at each level sunk
// one item in flight; the next item is taken once the result sits in the output register
// reset clears the entry count, the arity (to 2) and the order (largest on top)
// top level of the d-ary heap priority queue; depends on dhpq_pkg, dhpq_ctrl, dhpq_dpath
module dary_heap_priority_queue_top #(
  parameter int unsigned CAPACITY     = dhpq_pkg::DefCapacity,
  parameter int unsigned KEY_BITS     = dhpq_pkg::DefKeyBits,
  parameter int unsigned PAYLOAD_BITS = dhpq_pkg::DefPayloadBits,
  parameter int unsigned MAX_ARITY    = dhpq_pkg::DefMaxArity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // item input
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dhpq_pkg::in_item_t  in_item_i,
  // item output
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dhpq_pkg::out_item_t out_item_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [3:0]           arity_q;
  logic                 order_q;
  logic                 cfg_wr;
  dhpq_pkg::reg_e       reg_sel;
  dhpq_pkg::dp_cmd_t    cmd;
  dhpq_pkg::dp_status_t status;

  // register index sits above the byte offset
  assign reg_sel = dhpq_pkg::reg_e'(paddr[2]);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arity_q <= 4'd2;
      order_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        dhpq_pkg::REG_ARITY: arity_q <= pwdata[3:0];
        dhpq_pkg::REG_ORDER: order_q <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      dhpq_pkg::REG_ARITY: prdata = {28'd0, arity_q};
      dhpq_pkg::REG_ORDER: prdata = {31'd0, order_q};
      default:             prdata = '0;
    endcase
  end

  // sequencer: one state per phase of a push or pop
  dhpq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // entry memory, sift registers and the output register
  dhpq_dpath #(
    .CAPACITY    (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS),
    .MAX_ARITY   (MAX_ARITY)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .arity_i    (arity_q),
    .order_i    (order_q),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_item_i  (in_item_i),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

endmodule

@@ rtl/dhpq_div.sv @@
// restoring divider, one quotient bit per cycle, used for the parent index
// depends on nothing outside this file
module dhpq_div #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [AW-1:0] quo_o
);

  localparam int unsigned LW = $clog2(AW + 1);

  logic [AW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [LW-1:0] left_q, left_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   shifted;
  logic          fits;

  always_comb begin
    shifted = {rem_q, quo_q[AW-1]};
    fits    = shifted >= {1'b0, divisor_i};
    quo_d   = quo_q;
    rem_d   = rem_q;
    left_d  = left_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      left_d = LW'(AW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d  = AW'({quo_q, fits});
      rem_d  = fits ? DW'(shifted - {1'b0, divisor_i}) : DW'(shifted);
      left_d = left_q - 1'b1;
      if (left_q == LW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      left_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/dhpq_dpath.sv @@
// heap datapath: entry memory, moving entry, child scan, result and output register
// depends on dhpq_pkg and dhpq_div
module dhpq_dpath #(
  parameter int unsigned CAPACITY     = dhpq_pkg::DefCapacity,
  parameter int unsigned KEY_BITS     = dhpq_pkg::DefKeyBits,
  parameter int unsigned PAYLOAD_BITS = dhpq_pkg::DefPayloadBits,
  parameter int unsigned MAX_ARITY    = dhpq_pkg::DefMaxArity
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [3:0]           arity_i,
  input  logic                 order_i,
  input  dhpq_pkg::dp_cmd_t    cmd_i,
  output dhpq_pkg::dp_status_t status_o,
  input  dhpq_pkg::in_item_t   in_item_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output dhpq_pkg::out_item_t  out_item_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = $clog2(MAX_ARITY + 1);
  localparam int unsigned FW = AW + DW + 1;

  logic [KEY_BITS-1:0]     key_mem [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_mem [CAPACITY];

  logic                    we, re;
  logic [AW-1:0]           waddr, raddr;
  logic [KEY_BITS-1:0]     wkey;
  logic [PAYLOAD_BITS-1:0] wpay;
  logic [KEY_BITS-1:0]     rd_key_q;
  logic [PAYLOAD_BITS-1:0] rd_pay_q;

  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              func_q, func_d;
  logic [KEY_BITS-1:0]     mov_key_q, mov_key_d, best_key_q, best_key_d;
  logic [PAYLOAD_BITS-1:0] mov_pay_q, mov_pay_d, best_pay_q, best_pay_d;
  logic [AW-1:0]           pos_q, pos_d, best_idx_q, best_idx_d, ra_q, ra_d;
  logic                    best_first_q, best_first_d;
  logic [CW-1:0]           c_q, c_d, end_q, end_d;
  logic                    res_valid_q, res_valid_d;
  logic [31:0]             res_key_q, res_key_d, res_pay_q, res_pay_d;
  logic [1:0]              res_stat_q, res_stat_d;
  dhpq_pkg::out_item_t     out_q, out_d;

  logic [DW-1:0]           eff_d;
  logic [FW-1:0]           first_w, end_w;
  logic [CW-1:0]           end_c;
  logic                    dn_leaf, dn_more, up_move, dn_move;
  logic                    div_start, div_done;
  logic [AW-1:0]           div_quo;

  function automatic logic better(input logic ord, input logic [KEY_BITS-1:0] a,
                                  input logic [KEY_BITS-1:0] b);
    better = ord ? (a < b) : (a > b);
  endfunction

  // arity clamped into the supported range
  always_comb begin
    if (int'(arity_i) < 2) begin
      eff_d = DW'(2);
    end else if (int'(arity_i) > int'(MAX_ARITY)) begin
      eff_d = DW'(MAX_ARITY);
    end else begin
      eff_d = DW'(arity_i);
    end
  end

  assign first_w = FW'(pos_q) * FW'(eff_d) + FW'(1);
  assign end_w   = first_w + FW'(eff_d);
  assign end_c   = (end_w > FW'(cnt_q)) ? cnt_q : CW'(end_w);
  assign dn_leaf = first_w >= FW'(cnt_q);
  assign dn_more = c_q < end_q;
  assign up_move = better(order_i, mov_key_q, rd_key_q);
  assign dn_move = better(order_i, best_key_q, mov_key_q);

  assign div_start = cmd_i.op == dhpq_pkg::OP_DIV_START;

  dhpq_div #(
    .AW(AW),
    .DW(DW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(pos_q - AW'(1)),
    .divisor_i (eff_d),
    .done_o    (div_done),
    .quo_o     (div_quo)
  );

  always_comb begin
    we    = 1'b0;
    waddr = pos_q;
    wkey  = mov_key_q;
    wpay  = mov_pay_q;
    re    = 1'b0;
    raddr = '0;
    cnt_d        = cnt_q;
    func_d       = func_q;
    mov_key_d    = mov_key_q;
    mov_pay_d    = mov_pay_q;
    pos_d        = pos_q;
    best_key_d   = best_key_q;
    best_pay_d   = best_pay_q;
    best_idx_d   = best_idx_q;
    best_first_d = best_first_q;
    ra_d         = ra_q;
    c_d          = c_q;
    end_d        = end_q;
    res_valid_d  = res_valid_q;
    res_key_d    = res_key_q;
    res_pay_d    = res_pay_q;
    res_stat_d   = res_stat_q;
    unique case (cmd_i.op) inside
      dhpq_pkg::OP_NONE: begin
      end
      dhpq_pkg::OP_ACCEPT: begin
        func_d      = in_item_i.func;
        mov_key_d   = KEY_BITS'(in_item_i.key);
        mov_pay_d   = PAYLOAD_BITS'(in_item_i.payload);
        pos_d       = AW'(cnt_q);
        res_valid_d = 1'b0;
        res_key_d   = '0;
        res_pay_d   = '0;
        res_stat_d  = dhpq_pkg::ST_OK;
      end
      dhpq_pkg::OP_FULL:  res_stat_d = dhpq_pkg::ST_FULL;
      dhpq_pkg::OP_EMPTY: res_stat_d = dhpq_pkg::ST_EMPTY;
      dhpq_pkg::OP_CLEAR: cnt_d = '0;
      dhpq_pkg::OP_PUSH:  cnt_d = cnt_q + CW'(1);
      dhpq_pkg::OP_DIV_START: begin
      end
      dhpq_pkg::OP_UP_READ: begin
        re    = 1'b1;
        raddr = div_quo;
      end
      dhpq_pkg::OP_UP_STEP: begin
        // parent moves down into the hole
        we    = 1'b1;
        wkey  = rd_key_q;
        wpay  = rd_pay_q;
        pos_d = div_quo;
      end
      dhpq_pkg::OP_PLACE: we = 1'b1;
      dhpq_pkg::OP_RD_ROOT: begin
        re    = 1'b1;
        raddr = '0;
      end
      dhpq_pkg::OP_TAKE, dhpq_pkg::OP_POP_TAKE: begin
        res_valid_d = 1'b1;
        res_key_d   = 32'(rd_key_q);
        res_pay_d   = 32'(rd_pay_q);
        if (cmd_i.op == dhpq_pkg::OP_POP_TAKE) begin
          re    = 1'b1;
          raddr = AW'(cnt_q - CW'(1));
          cnt_d = cnt_q - CW'(1);
        end
      end
      dhpq_pkg::OP_LAST_LOAD: begin
        mov_key_d = rd_key_q;
        mov_pay_d = rd_pay_q;
        pos_d     = '0;
      end
      dhpq_pkg::OP_DN_INIT: begin
        re           = 1'b1;
        raddr        = AW'(first_w);
        ra_d         = AW'(first_w);
        c_d          = CW'(first_w) + CW'(1);
        end_d        = end_c;
        best_first_d = 1'b1;
      end
      dhpq_pkg::OP_DN_ACC: begin
        // strict compare keeps the first best child
        if (best_first_q || better(order_i, rd_key_q, best_key_q)) begin
          best_key_d = rd_key_q;
          best_pay_d = rd_pay_q;
          best_idx_d = ra_q;
        end
        best_first_d = 1'b0;
        if (dn_more) begin
          re    = 1'b1;
          raddr = AW'(c_q);
          ra_d  = AW'(c_q);
          c_d   = c_q + CW'(1);
        end
      end
      default: begin
      end
    endcase
    if (cmd_i.op2 == dhpq_pkg::OP2_DN_STEP) begin
      we    = 1'b1;
      wkey  = best_key_q;
      wpay  = best_pay_q;
      pos_d = best_idx_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    if (cmd_i.op2 == dhpq_pkg::OP2_OUT) begin
      out_valid_d       = 1'b1;
      out_d.entry_valid = res_valid_q;
      out_d.top_key     = res_key_q;
      out_d.top_payload = res_pay_q;
      out_d.count       = 11'(cnt_q);
      out_d.status      = res_stat_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      pay_mem[waddr] <= wpay;
    end
    if (re) begin
      rd_key_q <= key_mem[raddr];
      rd_pay_q <= pay_mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    mov_key_q    <= mov_key_d;
    mov_pay_q    <= mov_pay_d;
    pos_q        <= pos_d;
    best_key_q   <= best_key_d;
    best_pay_q   <= best_pay_d;
    best_idx_q   <= best_idx_d;
    best_first_q <= best_first_d;
    ra_q         <= ra_d;
    c_q          <= c_d;
    end_q        <= end_d;
    res_valid_q  <= res_valid_d;
    res_key_q    <= res_key_d;
    res_pay_q    <= res_pay_d;
    res_stat_q   <= res_stat_d;
    out_q        <= out_d;
  end

  always_comb begin
    status_o.func     = dhpq_pkg::func_e'(func_q);
    status_o.full     = cnt_q == CW'(CAPACITY);
    status_o.empty    = cnt_q == '0;
    status_o.pos_zero = pos_q == '0;
    status_o.div_done = div_done;
    status_o.up_move  = up_move;
    status_o.dn_leaf  = dn_leaf;
    status_o.dn_more  = dn_more;
    status_o.dn_move  = dn_move;
    status_o.out_busy = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op2 == dhpq_pkg::OP2_OUT |=> out_valid_q)
    else $error("result not presented after load");

endmodule

@@ rtl/dhpq_ctrl.sv @@
// heap controller: sequences push, pop, peek and clear through the datapath
// depends on dhpq_pkg
module dhpq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dhpq_pkg::dp_status_t status_i,
  output dhpq_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_CHK,
    S_UP_DIV,
    S_UP_CMP,
    S_ROOT,
    S_LAST,
    S_DN_CHK,
    S_DN_ACC,
    S_DN_DEC,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = dhpq_pkg::OP_NONE;
    cmd_o.op2  = dhpq_pkg::OP2_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = dhpq_pkg::OP_ACCEPT;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.func) inside
          dhpq_pkg::FUNC_PUSH: begin
            if (status_i.full) begin
              cmd_o.op = dhpq_pkg::OP_FULL;
              state_d  = S_FIN;
            end else begin
              cmd_o.op = dhpq_pkg::OP_PUSH;
              state_d  = S_UP_CHK;
            end
          end
          dhpq_pkg::FUNC_POP, dhpq_pkg::FUNC_PEEK: begin
            if (status_i.empty) begin
              cmd_o.op = dhpq_pkg::OP_EMPTY;
              state_d  = S_FIN;
            end else begin
              cmd_o.op = dhpq_pkg::OP_RD_ROOT;
              state_d  = S_ROOT;
            end
          end
          default: begin
            cmd_o.op = dhpq_pkg::OP_CLEAR;
            state_d  = S_FIN;
          end
        endcase
      end
      S_UP_CHK: begin
        if (status_i.pos_zero) begin
          cmd_o.op = dhpq_pkg::OP_PLACE;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = dhpq_pkg::OP_DIV_START;
          state_d  = S_UP_DIV;
        end
      end
      S_UP_DIV: begin
        if (status_i.div_done) begin
          cmd_o.op = dhpq_pkg::OP_UP_READ;
          state_d  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (status_i.up_move) begin
          cmd_o.op = dhpq_pkg::OP_UP_STEP;
          state_d  = S_UP_CHK;
        end else begin
          cmd_o.op = dhpq_pkg::OP_PLACE;
          state_d  = S_FIN;
        end
      end
      S_ROOT: begin
        if (status_i.func == dhpq_pkg::FUNC_POP) begin
          cmd_o.op = dhpq_pkg::OP_POP_TAKE;
          state_d  = S_LAST;
        end else begin
          cmd_o.op = dhpq_pkg::OP_TAKE;
          state_d  = S_FIN;
        end
      end
      S_LAST: begin
        cmd_o.op = dhpq_pkg::OP_LAST_LOAD;
        state_d  = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (status_i.dn_leaf) begin
          cmd_o.op = dhpq_pkg::OP_PLACE;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = dhpq_pkg::OP_DN_INIT;
          state_d  = S_DN_ACC;
        end
      end
      S_DN_ACC: begin
        cmd_o.op = dhpq_pkg::OP_DN_ACC;
        if (!status_i.dn_more) begin
          state_d = S_DN_DEC;
        end
      end
      S_DN_DEC: begin
        if (status_i.dn_move) begin
          cmd_o.op2 = dhpq_pkg::OP2_DN_STEP;
          state_d   = S_DN_CHK;
        end else begin
          cmd_o.op = dhpq_pkg::OP_PLACE;
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.op2 = dhpq_pkg::OP2_OUT;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> state_q == S_UP_DIV)
    else $error("divider finished outside the parent wait");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_DISPATCH)
    else $error("accepted item not dispatched");

endmodule
